[src/bsalu_pkg.sv]
package bsalu_pkg;

    localparam int DataW = 4;
    localparam int AddrW = 4;

    typedef enum logic [2:0] {
        SRC_AQ = 3'd0,
        SRC_AB = 3'd1,
        SRC_ZQ = 3'd2,
        SRC_ZB = 3'd3,
        SRC_ZA = 3'd4,
        SRC_DA = 3'd5,
        SRC_DQ = 3'd6,
        SRC_DZ = 3'd7
    } t_src;

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUBR  = 3'd1,
        FN_SUBS  = 3'd2,
        FN_OR    = 3'd3,
        FN_AND   = 3'd4,
        FN_NOTRS = 3'd5,
        FN_EXOR  = 3'd6,
        FN_EXNOR = 3'd7
    } t_fn;

    typedef enum logic [2:0] {
        DST_QREG  = 3'd0,
        DST_NOP   = 3'd1,
        DST_RAMA  = 3'd2,
        DST_RAMF  = 3'd3,
        DST_RAMQD = 3'd4,
        DST_RAMD  = 3'd5,
        DST_RAMQU = 3'd6,
        DST_RAMU  = 3'd7
    } t_dst;

    typedef logic [DataW-1:0] t_nyb;

    typedef struct packed {
        t_nyb f;
        logic cy;
        logic ov;
    } t_alu_res;

    localparam t_nyb NybAll  = 4'hF;
    localparam t_nyb NybNone = 4'h0;

endpackage

[src/bsalu_core.sv]
module bsalu_core
    import bsalu_pkg::*;
(
    input  t_nyb     i_a,
    input  t_nyb     i_b,
    input  t_nyb     i_q,
    input  t_nyb     i_d,
    input  t_src     i_src,
    input  t_fn      i_fn,
    input  logic     i_c,
    output t_alu_res o_res
);

    function automatic logic look_c4(t_nyb x, t_nyb y, logic c);
        t_nyb p;
        t_nyb g;
        p = x | y;
        g = x & y;
        return g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | (p[3] & p[2] & p[1] & g[0])
            | (p[3] & p[2] & p[1] & p[0] & c);
    endfunction

    function automatic logic look_c3(t_nyb x, t_nyb y, logic c);
        t_nyb p;
        t_nyb g;
        p = x | y;
        g = x & y;
        return g[2] | (p[2] & g[1]) | (p[2] & p[1] & g[0]) | (p[2] & p[1] & p[0] & c);
    endfunction

    function automatic logic xor_carry(t_nyb x, t_nyb y, logic c);
        t_nyb p;
        t_nyb g;
        p = x | y;
        g = x & y;
        return ~(g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1])
            | (p[3] & p[2] & p[1] & p[0] & g[0] & ~c));
    endfunction

    function automatic logic xor_ovr(t_nyb x, t_nyb y, logic c);
        t_nyb p;
        t_nyb g;
        logic lo;
        logic hi;
        p  = x | y;
        g  = x & y;
        lo = p[2] | (g[2] & p[1]) | (g[2] & g[1] & p[0]) | (g[2] & g[1] & g[0] & c);
        hi = p[3] | (g[3] & p[2]) | (g[3] & g[2] & p[1]) | (g[3] & g[2] & g[1] & p[0])
            | (g[3] & g[2] & g[1] & g[0] & c);
        return lo ^ hi;
    endfunction

    t_nyb r;
    t_nyb s;
    t_nyb nr;
    t_nyb ns;
    logic [DataW:0] sum;

    always_comb begin
        case (i_src)
            SRC_AQ, SRC_AB: r = i_a;
            SRC_ZQ, SRC_ZB, SRC_ZA: r = NybNone;
            default: r = i_d;
        endcase
        case (i_src)
            SRC_AQ, SRC_ZQ, SRC_DQ: s = i_q;
            SRC_AB, SRC_ZB: s = i_b;
            SRC_ZA, SRC_DA: s = i_a;
            default: s = NybNone;
        endcase
    end

    assign nr = ~r;
    assign ns = ~s;

    always_comb begin
        sum   = '0;
        o_res = '0;
        case (i_fn)
            FN_ADD: begin
                sum      = {1'b0, r} + {1'b0, s} + {{DataW{1'b0}}, i_c};
                o_res.f  = sum[DataW-1:0];
                o_res.cy = look_c4(r, s, i_c);
                o_res.ov = look_c3(r, s, i_c) ^ look_c4(r, s, i_c);
            end
            FN_SUBR: begin
                sum      = {1'b0, s} + {1'b0, nr} + {{DataW{1'b0}}, i_c};
                o_res.f  = sum[DataW-1:0];
                o_res.cy = look_c4(nr, s, i_c);
                o_res.ov = look_c3(nr, s, i_c) ^ look_c4(nr, s, i_c);
            end
            FN_SUBS: begin
                sum      = {1'b0, r} + {1'b0, ns} + {{DataW{1'b0}}, i_c};
                o_res.f  = sum[DataW-1:0];
                o_res.cy = look_c4(r, ns, i_c);
                o_res.ov = look_c3(r, ns, i_c) ^ look_c4(r, ns, i_c);
            end
            FN_OR: begin
                o_res.f  = r | s;
                o_res.cy = ((r | s) != NybAll) | i_c;
                o_res.ov = o_res.cy;
            end
            FN_AND: begin
                o_res.f  = r & s;
                o_res.cy = ((r & s) != NybNone) | i_c;
                o_res.ov = o_res.cy;
            end
            FN_NOTRS: begin
                o_res.f  = nr & s;
                o_res.cy = ((nr & s) != NybNone) | i_c;
                o_res.ov = o_res.cy;
            end
            FN_EXOR: begin
                o_res.f  = r ^ s;
                o_res.cy = xor_carry(nr, s, i_c);
                o_res.ov = xor_ovr(nr, s, i_c);
            end
            default: begin
                o_res.f  = ~(r ^ s);
                o_res.cy = xor_carry(r, s, i_c);
                o_res.ov = xor_ovr(r, s, i_c);
            end
        endcase
    end

endmodule

[src/bit_slice_alu_with_register_file.sv]
// A request is accepted at a clock edge that reads the register file and loads
// the execute stage; the ALU result then goes into the output register.
// Throughput: one request per cycle while o_stall is low; the register file has two
// read ports and one write port, and a write in the same cycle as a read of that
// entry is forwarded.
// Reset clears all registers and Q at once through per-entry valid bits.
module bit_slice_alu_with_register_file
    import bsalu_pkg::*;
#(
    parameter int NUM_REGS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_a_addr,
    input  logic [3:0] i_b_addr,
    input  logic [2:0] i_source_sel,
    input  logic [2:0] i_function_sel,
    input  logic [2:0] i_dest_sel,
    input  logic [3:0] i_data_in,
    input  logic       i_carry_in,
    input  logic       i_ram_lsb_in,
    input  logic       i_ram_msb_in,
    input  logic       i_q_lsb_in,
    input  logic       i_q_msb_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_y_out,
    output logic       o_carry_out,
    output logic       o_overflow,
    output logic       o_f_msb,
    output logic       o_ram_lsb_out,
    output logic       o_ram_msb_out,
    output logic       o_q_lsb_out,
    output logic       o_q_msb_out,
    output logic       o_down_shift_drive,
    output logic       o_up_shift_drive
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [AddrW:0] NREG = (AddrW + 1)'(NUM_REGS);

    // register file and per-entry valid bits
    t_nyb              r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    t_nyb              r_rd_a;
    t_nyb              r_rd_b;
    t_nyb              r_q;

    // last write, for a read issued at the same edge
    logic              r_fwd_v;
    logic [AW-1:0]     r_fwd_addr;
    t_nyb              r_fwd_data;

    // execute stage
    logic              r_s1v;
    logic              r_s1_a_ok;
    logic              r_s1_b_ok;
    logic [AW-1:0]     r_s1_a_idx;
    logic [AW-1:0]     r_s1_b_idx;
    t_src              r_s1_src;
    t_fn               r_s1_fn;
    t_dst              r_s1_dst;
    t_nyb              r_s1_d;
    logic              r_s1_c;
    logic              r_s1_rli;
    logic              r_s1_rmi;
    logic              r_s1_qli;
    logic              r_s1_qmi;

    // output register
    logic              r_ov;
    t_nyb              r_y;
    logic              r_cy;
    logic              r_ovr;
    logic              r_fmsb;
    logic              r_rlo;
    logic              r_rmo;
    logic              r_qlo;
    logic              r_qmo;
    logic              r_dn;
    logic              r_up;

    logic              out_free;
    logic              s1_fire;
    logic              load_s1;
    logic              a_ok;
    logic              b_ok;
    logic [AW-1:0]     a_idx;
    logic [AW-1:0]     b_idx;
    t_nyb              a_val;
    t_nyb              b_val;
    t_alu_res          res;
    logic              dn;
    logic              up;
    logic              we;
    t_nyb              wdata;
    t_nyb              n_q;
    t_nyb              n_y;

    assign out_free = !r_ov || !i_stall;
    assign s1_fire  = r_s1v && out_free;
    assign o_stall  = r_s1v && !out_free;
    assign load_s1  = i_valid && !o_stall;

    assign a_ok  = {1'b0, i_a_addr} < NREG;
    assign b_ok  = {1'b0, i_b_addr} < NREG;
    assign a_idx = i_a_addr[AW-1:0];
    assign b_idx = i_b_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_rd_a <= r_mem[a_idx];
            r_rd_b <= r_mem[b_idx];
        end
        if (s1_fire && we) begin
            r_mem[r_s1_b_idx] <= wdata;
        end
    end

    // operand values: unwritten or out-of-range entries read as zero
    always_comb begin
        if (!r_s1_a_ok || !r_vld[r_s1_a_idx]) begin
            a_val = NybNone;
        end else if (r_fwd_v && r_fwd_addr == r_s1_a_idx) begin
            a_val = r_fwd_data;
        end else begin
            a_val = r_rd_a;
        end
        if (!r_s1_b_ok || !r_vld[r_s1_b_idx]) begin
            b_val = NybNone;
        end else if (r_fwd_v && r_fwd_addr == r_s1_b_idx) begin
            b_val = r_fwd_data;
        end else begin
            b_val = r_rd_b;
        end
    end

    bsalu_core u_core (
        .i_a   (a_val),
        .i_b   (b_val),
        .i_q   (r_q),
        .i_d   (r_s1_d),
        .i_src (r_s1_src),
        .i_fn  (r_s1_fn),
        .i_c   (r_s1_c),
        .o_res (res)
    );

    assign dn = (r_s1_dst == DST_RAMQD) || (r_s1_dst == DST_RAMD);
    assign up = (r_s1_dst == DST_RAMQU) || (r_s1_dst == DST_RAMU);
    assign we = r_s1_b_ok && (r_s1_dst != DST_QREG) && (r_s1_dst != DST_NOP);
    assign n_y = (r_s1_dst == DST_RAMA) ? a_val : res.f;

    always_comb begin
        case (r_s1_dst)
            DST_RAMQD, DST_RAMD: wdata = {r_s1_rmi, res.f[3:1]};
            DST_RAMQU, DST_RAMU: wdata = {res.f[2:0], r_s1_rli};
            default: wdata = res.f;
        endcase
        case (r_s1_dst)
            DST_QREG: n_q = res.f;
            DST_RAMQD: n_q = {r_s1_qmi, r_q[3:1]};
            DST_RAMQU: n_q = {r_q[2:0], r_s1_qli};
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q     <= NybNone;
            r_fwd_v <= 1'b0;
            r_s1v   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_q <= n_q;
                if (we) begin
                    r_vld[r_s1_b_idx] <= 1'b1;
                end
            end
            if (load_s1) begin
                r_fwd_v <= s1_fire && we;
            end
            if (load_s1) begin
                r_s1v <= 1'b1;
            end else if (s1_fire) begin
                r_s1v <= 1'b0;
            end
            if (s1_fire) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_fwd_addr <= r_s1_b_idx;
            r_fwd_data <= wdata;
            r_s1_a_ok  <= a_ok;
            r_s1_b_ok  <= b_ok;
            r_s1_a_idx <= a_idx;
            r_s1_b_idx <= b_idx;
            r_s1_src   <= t_src'(i_source_sel);
            r_s1_fn    <= t_fn'(i_function_sel);
            r_s1_dst   <= t_dst'(i_dest_sel);
            r_s1_d     <= i_data_in;
            r_s1_c     <= i_carry_in;
            r_s1_rli   <= i_ram_lsb_in;
            r_s1_rmi   <= i_ram_msb_in;
            r_s1_qli   <= i_q_lsb_in;
            r_s1_qmi   <= i_q_msb_in;
        end
        // hold the result while stalled
        if (s1_fire) begin
            r_y    <= n_y;
            r_cy   <= res.cy;
            r_ovr  <= res.ov;
            r_fmsb <= res.f[3];
            r_rlo  <= dn & res.f[0];
            r_rmo  <= up & res.f[3];
            r_qlo  <= dn & r_q[0];
            r_qmo  <= up & r_q[3];
            r_dn   <= dn;
            r_up   <= up;
        end
    end

    assign o_valid            = r_ov;
    assign o_y_out            = r_y;
    assign o_carry_out        = r_cy;
    assign o_overflow         = r_ovr;
    assign o_f_msb            = r_fmsb;
    assign o_ram_lsb_out      = r_rlo;
    assign o_ram_msb_out      = r_rmo;
    assign o_q_lsb_out        = r_qlo;
    assign o_q_msb_out        = r_qmo;
    assign o_down_shift_drive = r_dn;
    assign o_up_shift_drive   = r_up;

endmodule
